>>> rtl/pps_pkg.sv
package pps_pkg;

  // Field widths of the input and result words.
  localparam int unsigned AddrW     = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned ColourW   = 4;
  localparam int unsigned RgbW      = 24;
  localparam int unsigned CountW    = 4;
  localparam int unsigned PalDepth  = 16;
  localparam int unsigned PalAddrW  = 4;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 32;

  // Reset value of the base address register.
  localparam logic [AddrW-1:0] BaseReset = 16'hFE20;

  // Control register bits.
  localparam int unsigned CtlFlashBit = 0;
  localparam int unsigned CtlFastBit  = 4;

  // Shift rate for a control byte: mode bits 3..2 select 8, 4, 2 or 1 ticks.
  function automatic logic [CountW-1:0] rate_of_control(input logic [ByteW-1:0] ctl);
    logic [CountW-1:0] rate;
    case (ctl[3:2])
      2'd0:    rate = 4'd8;
      2'd1:    rate = 4'd4;
      2'd2:    rate = 4'd2;
      default: rate = 4'd1;
    endcase
    return rate;
  endfunction

endpackage

>>> rtl/pps_ram.sv
module pps_ram #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port; the read data is registered and holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/palette_pixel_shifter.sv
// Palette and pixel shifter of a video ULA, one input word per 16 MHz tick.
// The slave stream carries one tick: the processor bus access, the 1 MHz and
// 2 MHz edge flags, the display byte and the cursor flag. A write at the base
// address loads the control register, a write at base+1 loads one palette
// entry; such ticks and bus reads there give no output word. Every other tick
// gives one master word with the pixel colour.
// The user must load the base address through cfg_we_i / cfg_wdata_i only
// while idle; the block itself does not enforce it. The palette lives in a
// 16 x 4 synchronous RAM. A pixel tick updates the shift register and
// countdown in the cycle it is accepted and issues the palette read; the
// RAM data is then registered into the output word. Throughput is one word
// per cycle while the receiver does not stall, set by the single palette
// read port. When the receiver stalls, the output register holds its word,
// the palette read stage holds its RAM data, and s_axis_tready drops while
// both are full and the receiver stalls.
// Reset returns control, shift register and countdown (eight) to their start
// values and clears the palette valid bits, so every entry reads as its own
// index until written; no clearing pass is needed.
module palette_pixel_shifter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pps_pkg::AddrW-1:0]     cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // bus_address[15:0], bus_is_read[16], write_byte[24:17], edge_1mhz[25],
  // edge_2mhz[26], display_byte[34:27], cursor_on[35], zero[39:36]
  input  logic [pps_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // pixel_rgb[23:0], physical_colour[27:24], zero[31:28]
  output logic [pps_pkg::OutDataW-1:0]  m_axis_tdata
);

  // Input field unpacking.
  logic [pps_pkg::AddrW-1:0] bus_address;
  logic                      bus_is_read;
  logic [pps_pkg::ByteW-1:0] write_byte;
  logic                      edge_1mhz;
  logic                      edge_2mhz;
  logic [pps_pkg::ByteW-1:0] display_byte;
  logic                      cursor_on;

  assign bus_address  = s_axis_tdata[15:0];
  assign bus_is_read  = s_axis_tdata[16];
  assign write_byte   = s_axis_tdata[24:17];
  assign edge_1mhz    = s_axis_tdata[25];
  assign edge_2mhz    = s_axis_tdata[26];
  assign display_byte = s_axis_tdata[34:27];
  assign cursor_on    = s_axis_tdata[35];

  // State registers.
  logic [pps_pkg::AddrW-1:0]    base_q;
  logic [pps_pkg::ByteW-1:0]    ctrl_q, ctrl_d;
  logic [pps_pkg::ByteW-1:0]    shift_q, shift_d;
  logic [pps_pkg::CountW-1:0]   count_q, count_d;
  logic [pps_pkg::PalDepth-1:0] pal_valid_q, pal_valid_d;

  // Read stage: a palette read is in flight or its data is held.
  logic                         rd_valid_q;
  logic [pps_pkg::PalAddrW-1:0] rd_addr_q;
  logic                         rd_entry_valid_q;
  logic                         rd_cursor_q;
  logic                         rd_flash_en_q;

  // Output register.
  logic                          out_valid_q;
  logic [pps_pkg::ColourW-1:0]   out_phys_q;
  logic [pps_pkg::RgbW-1:0]      out_rgb_q;

  logic in_fire, rd_adv, hit_ctrl, hit_pal, is_pixel, do_latch;
  logic [pps_pkg::AddrW:0]      pal_addr_ext;
  logic [pps_pkg::ByteW-1:0]    shift_lat;
  logic [pps_pkg::CountW-1:0]   count_dec;
  logic [pps_pkg::PalAddrW-1:0] logical;
  logic                         pal_we;
  logic [pps_pkg::ColourW-1:0]  ram_rdata;
  logic [pps_pkg::ColourW-1:0]  phys;
  logic                         invert;
  logic [pps_pkg::ByteW-1:0]    red, green, blue;

  // Handshake: the read stage moves on when the output register is free.
  assign rd_adv        = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !rd_valid_q || rd_adv;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Address decode; base+1 is computed one bit wider so it does not wrap.
  assign pal_addr_ext = {1'b0, base_q} + {{pps_pkg::AddrW{1'b0}}, 1'b1};
  assign hit_ctrl     = (bus_address == base_q);
  assign hit_pal      = !hit_ctrl && ({1'b0, bus_address} == pal_addr_ext);
  assign is_pixel     = !hit_ctrl && !hit_pal;
  assign pal_we       = in_fire && hit_pal && !bus_is_read;

  // Latch, colour gather and shift for a pixel tick.
  assign do_latch  = edge_1mhz || (edge_2mhz && ctrl_q[pps_pkg::CtlFastBit]);
  assign shift_lat = do_latch ? display_byte : shift_q;
  assign logical   = {shift_lat[7], shift_lat[5], shift_lat[3], shift_lat[1]};
  assign count_dec = count_q - 4'd1;

  always_comb begin
    ctrl_d      = ctrl_q;
    shift_d     = shift_q;
    count_d     = count_q;
    pal_valid_d = pal_valid_q;
    if (in_fire) begin
      if (hit_ctrl) begin
        if (!bus_is_read) begin
          ctrl_d  = write_byte;
          count_d = pps_pkg::rate_of_control(write_byte);
        end
      end else if (hit_pal) begin
        if (!bus_is_read) begin
          pal_valid_d[write_byte[7:4]] = 1'b1;
        end
      end else begin
        if (count_dec == '0) begin
          shift_d = {shift_lat[6:0], 1'b1};
          count_d = pps_pkg::rate_of_control(ctrl_q);
        end else begin
          shift_d = shift_lat;
          count_d = count_dec;
        end
      end
    end
  end

  // Palette memory.
  pps_ram #(
    .Width(pps_pkg::ColourW),
    .Depth(pps_pkg::PalDepth)
  ) u_pal_ram (
    .clk_i  (clk_i),
    .we_i   (pal_we),
    .waddr_i(write_byte[7:4]),
    .wdata_i(write_byte[3:0]),
    .re_i   (in_fire && is_pixel),
    .raddr_i(logical),
    .rdata_o(ram_rdata)
  );

  // Colour forming from the palette entry; an unwritten entry holds its index.
  assign phys   = rd_entry_valid_q ? ram_rdata : rd_addr_q;
  assign invert = !(phys[3] && rd_flash_en_q) ^ rd_cursor_q;
  assign red    = {pps_pkg::ByteW{phys[0] ^ invert}};
  assign green  = {pps_pkg::ByteW{phys[1] ^ invert}};
  assign blue   = {pps_pkg::ByteW{phys[2] ^ invert}};

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= pps_pkg::BaseReset;
      ctrl_q      <= '0;
      shift_q     <= '0;
      count_q     <= pps_pkg::rate_of_control('0);
      pal_valid_q <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      ctrl_q      <= ctrl_d;
      shift_q     <= shift_d;
      count_q     <= count_d;
      pal_valid_q <= pal_valid_d;
      if (s_axis_tready) begin
        rd_valid_q <= in_fire && is_pixel;
      end
      if (rd_adv) begin
        out_valid_q <= rd_valid_q;
      end
    end
  end

  // Payload of the read stage and the output register.
  always_ff @(posedge clk_i) begin
    if (in_fire && is_pixel) begin
      rd_addr_q        <= logical;
      rd_entry_valid_q <= pal_valid_q[logical];
      rd_cursor_q      <= cursor_on;
      rd_flash_en_q    <= ctrl_q[pps_pkg::CtlFlashBit];
    end
    if (rd_adv && rd_valid_q) begin
      out_phys_q <= phys;
      out_rgb_q  <= {red, green, blue};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_phys_q, out_rgb_q};

  // The shift countdown is never zero between ticks.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q != '0)
    else $error("shift countdown reached zero");

  // A blocked read stage keeps its word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_valid_q && !rd_adv) |=> rd_valid_q)
    else $error("read stage word lost under stall");

  // The input side is only held off while the read stage is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (rd_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without cause");

  // Palette valid bits are never cleared outside reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((pal_valid_q & $past(pal_valid_q)) == $past(pal_valid_q)))
    else $error("palette valid bit cleared");

endmodule
